// File: hdl/tmc_pkg.sv
// shared constants and rounding helpers for the transform matrix composer
package tmc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int RBITS     = 28;
  localparam int IN_W      = 320;
  localparam int OUT_W     = 128;
  localparam int USER_W    = 5;

  localparam logic [1:0] MAT_L2P  = 2'd0;
  localparam logic [1:0] MAT_P2L  = 2'd1;
  localparam logic [1:0] MAT_NORM = 2'd2;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;
  localparam logic signed [31:0] ONE_FX  = 32'sd1 <<< FRAC_BITS;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
    logic signed [31:0] r;
    if (v > 96'sd2147483647) r = SAT_MAX;
    else if (v < -96'sd2147483648) r = SAT_MIN;
    else r = v[31:0];
    return r;
  endfunction

  // round half up by RBITS then saturate
  function automatic logic signed [31:0] rnd_r(input logic signed [95:0] v);
    logic signed [95:0] t;
    t = (v + (96'sd1 <<< (RBITS - 1))) >>> RBITS;
    return sat32(t);
  endfunction

  // round half up by FRAC_BITS then saturate
  function automatic logic signed [31:0] rnd_f(input logic signed [95:0] v);
    logic signed [95:0] t;
    t = (v + (96'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return sat32(t);
  endfunction

endpackage

// File: hdl/trs_matrix_compose.sv
// top level: composes local-to-parent, parent-to-local and normal matrices
// column words leave one per cycle while out_tready does not stall them
// each accepted input word yields eleven column words from the output sequencer
// the pipeline runs in lockstep and stalls as a whole while the head item is sending
// rst_n (synchronous, active low) clears all valid bits and the column counter
// data registers are not reset
module trs_matrix_compose (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // trans_x, trans_y, trans_z, quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z
  input  logic [tmc_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // elem_row0, elem_row1, elem_row2, elem_row3
  output logic [tmc_pkg::OUT_W-1:0]  out_tdata,
  // which_matrix, column_index, zero_scale_flag
  output logic [tmc_pkg::USER_W-1:0] out_tuser,
  output logic                       out_tlast
);
  import tmc_pkg::*;

  localparam int DIVL = 2 * FRAC_BITS + 3;  // divider stages incl. input register
  localparam int LAT  = DIVL + 1;           // index of stage D in vld_r, stage A is 0

  typedef logic signed [31:0] s32_t;

  // pipeline advance: one stage at a time, whole pipe moves together
  logic adv, busy;
  logic [3:0] col_r, col_nxt;

  // input unpack
  s32_t t_in [3], q_in [4], s_in [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_in[i] = in_tdata[32*i +: 32];
      s_in[i] = in_tdata[32*(7+i) +: 32];
    end
    for (int i = 0; i < 4; i++) q_in[i] = in_tdata[32*(3+i) +: 32];
  end

  // stage A: clamp quaternion, products
  logic vld_r [LAT+1];
  s32_t t_a_r [3], s_a_r [3];
  logic signed [63:0] pp_r [9];  // xx yy zz xy xz yz wx wy wz
  s32_t qc [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (q_in[i] > 32'sd1073741824) qc[i] = 32'sd1073741824;
      else if (q_in[i] < -32'sd1073741824) qc[i] = -32'sd1073741824;
      else qc[i] = q_in[i];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      t_a_r <= t_in; s_a_r <= s_in;
      pp_r[0] <= qc[1] * qc[1]; pp_r[1] <= qc[2] * qc[2]; pp_r[2] <= qc[3] * qc[3];
      pp_r[3] <= qc[1] * qc[2]; pp_r[4] <= qc[1] * qc[3]; pp_r[5] <= qc[2] * qc[3];
      pp_r[6] <= qc[0] * qc[1]; pp_r[7] <= qc[0] * qc[2]; pp_r[8] <= qc[0] * qc[3];
    end
  end

  // stage B: rotation matrix, rounded to RBITS (entries stay within +-4.0)
  s32_t rot_r [3][3];
  s32_t t_b_r [3], s_b_r [3];
  function automatic s32_t rr(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = (v + (66'sd1 <<< (60 - RBITS - 1))) >>> (60 - RBITS);
    return t[31:0];
  endfunction
  always_ff @(posedge clk) begin
    if (adv) begin
      t_b_r <= t_a_r; s_b_r <= s_a_r;
      rot_r[0][0] <= rr((66'sd1 <<< 60) - 66'sd2 * (pp_r[1] + pp_r[2]));
      rot_r[1][0] <= rr(66'sd2 * (pp_r[3] + pp_r[8]));
      rot_r[2][0] <= rr(66'sd2 * (pp_r[4] - pp_r[7]));
      rot_r[0][1] <= rr(66'sd2 * (pp_r[3] - pp_r[8]));
      rot_r[1][1] <= rr((66'sd1 <<< 60) - 66'sd2 * (pp_r[0] + pp_r[2]));
      rot_r[2][1] <= rr(66'sd2 * (pp_r[5] + pp_r[6]));
      rot_r[0][2] <= rr(66'sd2 * (pp_r[4] + pp_r[7]));
      rot_r[1][2] <= rr(66'sd2 * (pp_r[5] - pp_r[6]));
      rot_r[2][2] <= rr((66'sd1 <<< 60) - 66'sd2 * (pp_r[0] + pp_r[1]));
    end
  end

  // reciprocals run alongside, fed from the same scale input as stage A
  s32_t inv_w [3];
  for (genvar i = 0; i < 3; i++) begin : g_rc
    tmc_recip u_rc (.clk(clk), .en(adv), .s(s_in[i]), .inv(inv_w[i]));
  end

  // delay rotation, translation, scale to meet the reciprocals
  localparam int DLY = DIVL - 2;
  s32_t rot_d_r [DLY][3][3];
  s32_t t_d_r [DLY][3], s_d_r [DLY][3];
  always_ff @(posedge clk) begin
    if (adv) begin
      rot_d_r[0] <= rot_r; t_d_r[0] <= t_b_r; s_d_r[0] <= s_b_r;
      for (int k = 1; k < DLY; k++) begin
        rot_d_r[k] <= rot_d_r[k-1]; t_d_r[k] <= t_d_r[k-1]; s_d_r[k] <= s_d_r[k-1];
      end
    end
  end

  // stage C: all products except final P column 3 terms; u = -(R^T t)
  s32_t m_r [3][3], pl_r [3][3], n_r [3][3], u_r [3], inv_c_r [3], t_c_r [3];
  logic zf_c_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m_r[i][j]  <= rnd_r(96'(64'(rot_d_r[DLY-1][i][j]) * 64'(s_d_r[DLY-1][j])));
          pl_r[i][j] <= rnd_r(96'(64'(rot_d_r[DLY-1][j][i]) * 64'(inv_w[i])));
        end
        // round, negate, then saturate
        u_r[i] <= sat32(-((96'(64'(rot_d_r[DLY-1][0][i]) * 64'(t_d_r[DLY-1][0])
                             + 64'(rot_d_r[DLY-1][1][i]) * 64'(t_d_r[DLY-1][1])
                             + 64'(rot_d_r[DLY-1][2][i]) * 64'(t_d_r[DLY-1][2]))
                          + (96'sd1 <<< (RBITS - 1))) >>> RBITS));
      end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          n_r[i][j] <= ((s_d_r[DLY-1][0] == s_d_r[DLY-1][1]) &&
                        (s_d_r[DLY-1][0] == s_d_r[DLY-1][2]))
                       ? rnd_r(96'(64'(rot_d_r[DLY-1][i][j]) * 64'(s_d_r[DLY-1][j])))
                       : rnd_r(96'(64'(rot_d_r[DLY-1][i][j]) * 64'(inv_w[j])));
      inv_c_r <= inv_w;
      t_c_r   <= t_d_r[DLY-1];
      zf_c_r  <= (s_d_r[DLY-1][0] == 0) || (s_d_r[DLY-1][1] == 0) ||
                 (s_d_r[DLY-1][2] == 0);
    end
  end

  // stage D: P column 3
  s32_t m_h_r [3][3], pl_h_r [3][3], n_h_r [3][3], t_h_r [3], p3_r [3];
  logic zf_h_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      m_h_r <= m_r; pl_h_r <= pl_r; n_h_r <= n_r; t_h_r <= t_c_r; zf_h_r <= zf_c_r;
      for (int i = 0; i < 3; i++) p3_r[i] <= rnd_f(96'(64'(inv_c_r[i]) * 64'(u_r[i])));
    end
  end

  // valid pipeline; entry at stage A
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAT; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_tvalid && in_tready;
      for (int k = 1; k <= LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // output sequencer holds the last stage for eleven columns
  logic head_v;
  assign head_v = vld_r[LAT];
  assign busy = head_v && (col_r != 4'd10 || (out_tvalid && !out_tready));
  assign adv  = !busy;
  assign in_tready = adv;

  always_comb begin
    col_nxt = col_r;
    if (head_v && !(out_tvalid && !out_tready))
      col_nxt = (col_r == 4'd10) ? 4'd0 : col_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  // column select
  logic [1:0] wm, ci;
  s32_t e [4];
  always_comb begin
    wm = MAT_L2P; ci = 2'd0;
    e[0] = '0; e[1] = '0; e[2] = '0; e[3] = '0;
    unique case (col_r)
      4'd0, 4'd1, 4'd2: begin
        ci = col_r[1:0];
        for (int i = 0; i < 3; i++) e[i] = m_h_r[i][col_r[1:0]];
      end
      4'd3: begin
        ci = 2'd3;
        for (int i = 0; i < 3; i++) e[i] = t_h_r[i];
        e[3] = ONE_FX;
      end
      4'd4, 4'd5, 4'd6: begin
        wm = MAT_P2L; ci = 2'(col_r - 4'd4);
        for (int i = 0; i < 3; i++) e[i] = pl_h_r[i][ci];
      end
      4'd7: begin
        wm = MAT_P2L; ci = 2'd3;
        for (int i = 0; i < 3; i++) e[i] = p3_r[i];
        e[3] = ONE_FX;
      end
      4'd8, 4'd9, 4'd10: begin
        wm = MAT_NORM; ci = 2'(col_r - 4'd8);
        for (int i = 0; i < 3; i++) e[i] = n_h_r[i][ci];
      end
      default: begin
        wm = MAT_L2P;
      end
    endcase
  end

  // output register
  logic ov_r, ol_r;
  logic [OUT_W-1:0]  od_r;
  logic [USER_W-1:0] ou_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; ol_r <= 1'b0;
    end else if (!ov_r || out_tready) begin
      ov_r <= head_v;
      ol_r <= head_v && (col_r == 4'd10);
    end
  end
  always_ff @(posedge clk) begin
    if ((!ov_r || out_tready) && head_v) begin
      od_r <= {e[3], e[2], e[1], e[0]};
      ou_r <= {zf_h_r, ci, wm};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

endmodule

// File: hdl/tmc_recip.sv
// pipelined restoring divider: 2^(2*FRAC_BITS) / s rounded, signed as s, zero gives SAT_MAX; one quotient bit per stage
module tmc_recip (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] s,
  output logic signed [31:0] inv
);
  import tmc_pkg::*;

  localparam int QW = 2 * FRAC_BITS + 2;  // quotient bits of 2^(2F+1)
  localparam int NW = 2 * FRAC_BITS + 2;  // numerator width

  logic [NW-1:0] rem_r [QW+1];
  logic [QW-1:0] quo_r [QW+1];
  logic [32:0]   mag_r [QW+1];
  logic          neg_r [QW+1];
  logic          zer_r [QW+1];
  logic [32:0]   mag;

  // q = round(N/m) = floor((2N/m + 1)/2), computed from 2N = 2^(2F+1)
  assign mag = s[31] ? (33'd0 - {s[31], s}) : {1'b0, s};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      quo_r[0] <= '0;
      mag_r[0] <= mag;
      neg_r[0] <= s[31];
      zer_r[0] <= (s == 32'sd0);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [NW:0] tr;
    logic        nb;
    assign nb = (k == 0);
    assign tr = {rem_r[k], nb};
    always_ff @(posedge clk) begin
      if (en) begin
        mag_r[k+1] <= mag_r[k];
        neg_r[k+1] <= neg_r[k];
        zer_r[k+1] <= zer_r[k];
        if (tr >= {{(NW-32){1'b0}}, mag_r[k]}) begin
          rem_r[k+1] <= NW'(tr - {{(NW-32){1'b0}}, mag_r[k]});
          quo_r[k+1] <= {quo_r[k][QW-2:0], 1'b1};
        end else begin
          rem_r[k+1] <= NW'(tr);
          quo_r[k+1] <= {quo_r[k][QW-2:0], 1'b0};
        end
      end
    end
  end

  logic [QW-1:0] q;
  logic signed [95:0] qs;
  assign q  = (quo_r[QW] + 1'b1) >> 1;
  assign qs = neg_r[QW] ? -$signed({62'd0, q}) : $signed({62'd0, q});
  assign inv = zer_r[QW] ? SAT_MAX : sat32(qs);

endmodule

// File: hdl/trs_matrix_compose_chk.sv
// port-level checker for the transform matrix composer, bound to the top level
module trs_matrix_compose_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic [4:0]   out_tuser,
  input logic         out_tlast
);
  import tmc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled word changed");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[1:0] == MAT_NORM && out_tuser[3:2] == 2'd2)
    else $error("tlast not on final normal column");
  a_row3: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == MAT_NORM |-> out_tdata[127:96] == 32'd0)
    else $error("normal matrix row 3 nonzero");
  a_cols: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[1:0] == MAT_L2P || out_tuser[1:0] == MAT_P2L ||
      out_tuser[1:0] == MAT_NORM)
    else $error("bad matrix code");
endmodule

bind trs_matrix_compose trs_matrix_compose_chk u_chk (.*);

// File: bench/tmc_checker.sv
// channel monitor, transform predictor and column comparator for the matrix composer
module tmc_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [319:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  input  logic [4:0]   out_tuser,
  input  logic         out_tlast,
  output int           errors,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tmc_pkg::*;

  localparam longint QLIM = 64'sd1 <<< 30;

  typedef struct {
    logic [1:0]  which;
    logic [1:0]  col;
    logic [31:0] row [4];
    logic        zflag;
    logic        last;
  } column_t;

  column_t columns_due[$];
  int      word_no;

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clipq(longint v);
    if (v > QLIM) return QLIM;
    if (v < -QLIM) return -QLIM;
    return v;
  endfunction

  function automatic longint fx_field(logic [319:0] d, int k);
    return longint'($signed(d[32*k +: 32]));
  endfunction

  task automatic push_column(logic [1:0] which, logic [1:0] col, longint e[4],
                             logic zf, logic last);
    column_t c;
    c.which = which;
    c.col   = col;
    for (int i = 0; i < 4; i++) c.row[i] = 32'(clip32(e[i]));
    c.zflag = zf;
    c.last  = last;
    columns_due.push_back(c);
  endtask

  // works out the eleven columns of one transform
  task automatic compose_columns(logic [319:0] d);
    longint t [3], s [3], inv [3], u [3], rot [3][3], e [4];
    longint w, x, y, z, one60, one, acc;
    longint unsigned mag, q;
    logic   zf, uniform;
    zf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      t[i] = fx_field(d, i);
      s[i] = fx_field(d, 7 + i);
    end
    w = clipq(fx_field(d, 3));
    x = clipq(fx_field(d, 4));
    y = clipq(fx_field(d, 5));
    z = clipq(fx_field(d, 6));
    one60 = 64'sd1 <<< 60;
    rot[0][0] = one60 - 2 * (y * y + z * z);
    rot[1][0] = 2 * (x * y + w * z);
    rot[2][0] = 2 * (x * z - w * y);
    rot[0][1] = 2 * (x * y - w * z);
    rot[1][1] = one60 - 2 * (x * x + z * z);
    rot[2][1] = 2 * (y * z + w * x);
    rot[0][2] = 2 * (x * z + w * y);
    rot[1][2] = 2 * (y * z - w * x);
    rot[2][2] = one60 - 2 * (x * x + y * y);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) rot[i][j] = round_shift(rot[i][j], 60 - RBITS);
    // reciprocal of scale, ties away from zero, zero saturates high
    for (int i = 0; i < 3; i++) begin
      if (s[i] == 0) begin
        zf = 1'b1;
        inv[i] = 64'sd2147483647;
      end else begin
        mag = (s[i] < 0) ? -s[i] : s[i];
        q = ((64'd1 << (2 * FRAC_BITS)) + mag / 2) / mag;
        inv[i] = clip32((s[i] < 0) ? -longint'(q) : longint'(q));
      end
    end
    one = 64'sd1 <<< FRAC_BITS;
    uniform = (s[0] == s[1]) && (s[0] == s[2]);
    // local-to-parent
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) e[i] = round_shift(rot[i][j] * s[j], RBITS);
      e[3] = 0;
      push_column(MAT_L2P, j[1:0], e, zf, 1'b0);
    end
    e[0] = t[0]; e[1] = t[1]; e[2] = t[2]; e[3] = one;
    push_column(MAT_L2P, 2'd3, e, zf, 1'b0);
    // parent-to-local
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) e[i] = round_shift(inv[i] * rot[j][i], RBITS);
      e[3] = 0;
      push_column(MAT_P2L, j[1:0], e, zf, 1'b0);
    end
    for (int i = 0; i < 3; i++) begin
      acc  = rot[0][i] * t[0] + rot[1][i] * t[1] + rot[2][i] * t[2];
      u[i] = clip32(-round_shift(acc, RBITS));
      e[i] = round_shift(inv[i] * u[i], FRAC_BITS);
    end
    e[3] = one;
    push_column(MAT_P2L, 2'd3, e, zf, 1'b0);
    // normal matrix
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++)
        e[i] = round_shift(rot[i][j] * (uniform ? s[j] : inv[j]), RBITS);
      e[3] = 0;
      push_column(MAT_NORM, j[1:0], e, zf, j == 2);
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("%0t: column word %0d: %s got %h want %h", $time, word_no, what, got, want);
  endtask

  initial begin
    errors  = 0;
    pending = 0;
    word_no = 0;
  end

  always @(posedge clk) begin
    column_t c;
    if (rst_n) begin
      if (in_tvalid && in_tready) compose_columns(in_tdata);
      if (out_tvalid && out_tready) begin
        if (columns_due.size() == 0) begin
          report("unexpected word", out_tdata[31:0], 32'h0);
        end else begin
          c = columns_due.pop_front();
          if (out_tuser[1:0] != c.which) report("which_matrix", out_tuser[1:0], c.which);
          if (out_tuser[3:2] != c.col) report("column_index", out_tuser[3:2], c.col);
          for (int i = 0; i < 4; i++)
            if (out_tdata[32*i +: 32] != c.row[i])
              report($sformatf("elem_row%0d", i), out_tdata[32*i +: 32], c.row[i]);
          if (out_tuser[4] != c.zflag) report("zero_scale_flag", out_tuser[4], c.zflag);
          if (out_tlast != c.last) report("last_column", out_tlast, c.last);
        end
        word_no++;
      end
    end
    pending = columns_due.size();
  end

endmodule

// File: bench/tb_top.sv
// top of the matrix composer bench: clock, reset, stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     WATCH_LIMIT = 3000;
  localparam logic [31:0] Q_ONE  = 32'h4000_0000;  // 1.0 in Q1.30
  localparam logic [31:0] Q_NONE = 32'hc000_0000;  // -1.0 in Q1.30
  localparam logic [31:0] FX_ONE = 32'h0001_0000;  // 1.0 in Q16.16

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [319:0] in_tdata;    // trans_x..z, quat_w..z, scale_x..z, 32 bits each from bit 0
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;   // elem_row0..3
  logic [4:0]   out_tuser;   // which_matrix, column_index, zero_scale_flag
  logic         out_tlast;
  int           errors;
  int           pending;
  int           quiet_cycles;
  bit           jitter;      // 0 gives stretches with no idling on either side
  int           stall_left;

  trs_matrix_compose uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  tmc_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: when jitter is set, drop tready after each taken word for a randomly drawn stall
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      stall_left = jitter ? $urandom_range(0, 8) : 0;
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog: too long with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("** trs_matrix_compose: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one transform word, after a random gap when jitter is set, and hold it until taken
  task automatic send_word(logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                           logic [31:0] qw, logic [31:0] qx, logic [31:0] qy,
                           logic [31:0] qz, logic [31:0] sx, logic [31:0] sy,
                           logic [31:0] sz);
    int gap;
    gap = jitter ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {sz, sy, sx, qz, qy, qx, qw, tz, ty, tx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // quaternion component: mostly inside the unit range, sometimes any 32-bit value
  function automatic logic [31:0] rand_quat();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
  endfunction

  // scale component: small magnitudes mostly, with zeros and full-range values
  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1, 2:    return $urandom;
      3:       return $urandom_range(1, 255) * ($urandom_range(0, 1) ? 1 : -1);
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_trans();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
  endfunction

  initial begin
    logic [31:0] sx;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    jitter    = 1'b0;
    rst_n     = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity rotation, unit and uniform scale
    send_word(0, 0, 0, Q_ONE, 0, 0, 0, FX_ONE, FX_ONE, FX_ONE);
    send_word(32'h0003_0000, 32'hfffe_0000, 32'h0000_8000,
              Q_ONE, 0, 0, 0, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
    // half turns about each axis, non-uniform scale
    send_word(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
              0, Q_ONE, 0, 0, 32'h0002_0000, FX_ONE, 32'h0000_8000);
    send_word(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
              0, 0, Q_ONE, 0, 32'h0000_4000, 32'h0003_0000, FX_ONE);
    send_word(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
              0, 0, 0, Q_NONE, FX_ONE, 32'hffff_0000, FX_ONE);
    // quarter turn about z, then equal quaternion components with non-uniform scale
    send_word(32'h0005_0000, 0, 0, 32'h2d41_3ccd, 0, 0, 32'h2d41_3ccd,
              FX_ONE, FX_ONE, FX_ONE);
    send_word(0, 0, 0, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000,
              FX_ONE, 32'h0002_0000, 32'h0003_0000);
    // zero quaternion and zero scale on each axis
    send_word(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0,
              0, FX_ONE, FX_ONE);
    send_word(32'h0001_0000, 0, 0, Q_ONE, 0, 0, 0, FX_ONE, 0, FX_ONE);
    send_word(0, 32'h0001_0000, 0, Q_ONE, 0, 0, 0, FX_ONE, FX_ONE, 0);
    send_word(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, Q_ONE, 0, 0, 0, 0, 0, 0);
    // quaternion components beyond the unit range get clamped
    send_word(0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h4000_0001, 32'hbfff_ffff,
              FX_ONE, FX_ONE, FX_ONE);
    send_word(32'h0001_0000, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              32'h7fff_ffff, FX_ONE, 32'h0002_0000, FX_ONE);
    // translation extremes, overflow of the inverse translation
    send_word(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, Q_ONE, 0, 0, 0,
              32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    send_word(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, Q_NONE, Q_ONE, Q_NONE, Q_ONE,
              32'hffff_ffff, 32'h0000_0002, 32'h8000_0000);
    // scale extremes, tiny scales saturate the reciprocal
    send_word(32'hffff_ffff, 32'h0000_0001, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(0, 0, 32'h0001_0000, 0, Q_ONE, Q_ONE, 0,
              32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001);
    send_word(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, Q_ONE, 0, 0, 0,
              32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    // reciprocal rounding and negative uniform scale
    send_word(0, 0, 0, Q_ONE, 0, 0, 0, 32'h0000_0003, 32'h0003_0000, 32'hfffd_0000);
    send_word(32'h1234_5678, 32'h8765_4321, 32'h0bad_f00d, 32'h3000_0000,
              32'hd000_0000, 32'h1000_0000, 32'hf000_0000,
              32'hfffe_0000, 32'hfffe_0000, 32'hfffe_0000);
    in_tvalid <= 1'b0;

    // hold off until every column of the directed part is back
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int n = 0; n < 500; n++) begin
      if (n % 100 == 0) jitter = (n % 200 == 0);
      sx = rand_scale();
      if ($urandom_range(0, 3) == 0)
        send_word(rand_trans(), rand_trans(), rand_trans(), rand_quat(), rand_quat(),
                  rand_quat(), rand_quat(), sx, sx, sx);
      else
        send_word(rand_trans(), rand_trans(), rand_trans(), rand_quat(), rand_quat(),
                  rand_quat(), rand_quat(), sx, rand_scale(), rand_scale());
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("** trs_matrix_compose: PASSED **");
    end else begin
      $display("** trs_matrix_compose: FAILED **");
    end
    $finish;
  end

endmodule
